### hdl/scc_pkg.sv
// ---------------------------------------------------------------------------
// scc_pkg
// Shared types and constants of the servo calibration controller: item
// structs, mode and register codes, reset values and the mode LED table.
// ---------------------------------------------------------------------------
package scc_pkg;

    localparam int KNOB_BITS = 12;
    localparam int DUTY_W    = 16;
    localparam int MAG_BITS  = 16;                    // magnitude operand of the scaler
    localparam int PROD_BITS = KNOB_BITS + MAG_BITS;
    localparam int CNT_BITS  = 4;                     // holds KNOB_BITS-1 and MAG_BITS-1

    localparam logic [KNOB_BITS-1:0] KNOB_MAX  = '1;
    localparam logic [KNOB_BITS-1:0] KNOB_HALF = KNOB_MAX >> 1;

    // modes
    localparam logic [2:0] MODE_OPENING     = 3'd0;
    localparam logic [2:0] MODE_SET_MIN     = 3'd1;
    localparam logic [2:0] MODE_SET_MAX     = 3'd2;
    localparam logic [2:0] MODE_DRIVE_MIN   = 3'd3;
    localparam logic [2:0] MODE_OPERATIONAL = 3'd4;
    localparam logic [2:0] MODE_PAUSED      = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_DEBOUNCE     = 3'd0;
    localparam logic [2:0] REG_LONG_PRESS   = 3'd1;
    localparam logic [2:0] REG_POLL_PERIOD  = 3'd2;
    localparam logic [2:0] REG_KNOB_THRESH  = 3'd3;
    localparam logic [2:0] REG_DUTY_ZERO    = 3'd4;
    localparam logic [2:0] REG_DUTY_FULL    = 3'd5;
    localparam logic [2:0] REG_REVERSE      = 3'd6;

    // register reset values
    localparam logic [7:0]           RST_DEBOUNCE    = 8'd10;
    localparam logic [15:0]          RST_LONG_PRESS  = 16'd1000;
    localparam logic [9:0]           RST_POLL_PERIOD = 10'd100;
    localparam logic [KNOB_BITS-1:0] RST_KNOB_THRESH = 12'd409;
    localparam logic [DUTY_W-1:0]    RST_DUTY_ZERO   = 16'd1638;
    localparam logic [DUTY_W-1:0]    RST_DUTY_FULL   = 16'd5571;

    // LED colors, bit0 red, bit1 green, bit2 blue
    localparam logic [2:0] LED_OFF     = 3'd0;
    localparam logic [2:0] LED_RED     = 3'd1;
    localparam logic [2:0] LED_GREEN   = 3'd2;
    localparam logic [2:0] LED_YELLOW  = 3'd3;
    localparam logic [2:0] LED_BLUE    = 3'd4;
    localparam logic [2:0] LED_MAGENTA = 3'd5;
    localparam logic [2:0] LED_WHITE   = 3'd7;

    typedef struct packed {
        logic                 btn_level;
        logic [KNOB_BITS-1:0] knob_sample;
    } in_item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] servo_duty;
        logic [2:0]        led_color;
        logic [2:0]        mode_code;
        logic              error_flash;
    } out_item_t;

    typedef struct packed {
        logic                 start;
        logic [KNOB_BITS-1:0] frac;
        logic [MAG_BITS-1:0]  mag;
    } scale_req_t;

    typedef struct packed {
        logic                done;
        logic [MAG_BITS-1:0] quot;
    } scale_rsp_t;

    function automatic logic [2:0] mode_led(input logic [2:0] mode);
        logic [2:0] color;
        unique case (mode)
            MODE_OPENING:     color = LED_BLUE;
            MODE_SET_MIN:     color = LED_RED;
            MODE_SET_MAX:     color = LED_YELLOW;
            MODE_DRIVE_MIN:   color = LED_GREEN;
            MODE_OPERATIONAL: color = LED_MAGENTA;
            MODE_PAUSED:      color = LED_WHITE;
            default:          color = LED_OFF;
        endcase
        return color;
    endfunction

endpackage

### hdl/servo_calibration_controller_core.sv
// ---------------------------------------------------------------------------
// servo_calibration_controller_core
// Per-tick servo calibration controller: button debounce and press timing,
// six-mode calibration sequence, knob to servo duty mapping, LED and flash.
// ---------------------------------------------------------------------------
// Usage: send one transaction per millisecond tick on s_ (button level and
// knob sample); each one yields exactly one result transaction on m_ (duty,
// LED color, mode, flash flag). Registers are written on the cfg_ channel,
// which is always ready; write them only while no tick is in flight.
// Each servo positioning runs two passes through the shared bit-serial
// scaler; a tick positions at most twice.
// Throughput is one tick at a time; s_ready is high only between ticks.
// The result sits in an output register: the next tick is accepted and
// processed while it waits, and only the final load stalls on m_ready.
// Reset (aresetn low, synchronous) loads the register defaults, enters the
// opening mode with full travel window and duty of position zero.
// ---------------------------------------------------------------------------
module servo_calibration_controller_core #(
    parameter int DUTY_BITS   = 16,
    parameter int FLASH_TICKS = 400
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  scc_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output scc_pkg::out_item_t m_payload,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import scc_pkg::*;

    localparam int FLASH_W = $clog2(FLASH_TICKS + 1);
    localparam logic [FLASH_W-1:0] FLASH_LAST = FLASH_W'(FLASH_TICKS - 1);
    localparam logic [DUTY_W-1:0]  DUTY_MASK  =
        DUTY_W'({DUTY_W{1'b1}} << (DUTY_W - DUTY_BITS));
    localparam logic [DUTY_W-1:0]  DUTY_RST   = RST_DUTY_ZERO & DUTY_MASK;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_EVT   = 4'd1;
    localparam logic [3:0] S_PRESS = 4'd2;
    localparam logic [3:0] S_POLL  = 4'd3;
    localparam logic [3:0] S_POS1  = 4'd4;
    localparam logic [3:0] S_W1    = 4'd5;
    localparam logic [3:0] S_POS2  = 4'd6;
    localparam logic [3:0] S_W2    = 4'd7;
    localparam logic [3:0] S_FIN   = 4'd8;

    // configuration
    logic [7:0]           deb_ticks_reg, deb_ticks_next;
    logic [15:0]          long_press_reg, long_press_next;
    logic [9:0]           poll_period_reg, poll_period_next;
    logic [KNOB_BITS-1:0] thresh_reg, thresh_next;
    logic [DUTY_W-1:0]    duty_zero_reg, duty_zero_next;
    logic [DUTY_W-1:0]    duty_full_reg, duty_full_next;
    logic                 reverse_reg, reverse_next;

    // sequencer
    logic [3:0]           state_reg, state_next;
    logic [3:0]           ret_reg, ret_next;
    logic                 btn_reg, btn_next;
    logic [KNOB_BITS-1:0] knob_reg, knob_next;
    logic                 paused_reg, paused_next;
    logic                 poll_act_reg, poll_act_next;
    logic                 short_reg, short_next;
    logic                 long_reg, long_next;
    logic [KNOB_BITS-1:0] rel_reg, rel_next;

    // tick state
    logic [31:0]          time_reg, time_next;
    logic [31:0]          deb_end_reg, deb_end_next;
    logic [31:0]          press_start_reg, press_start_next;
    logic                 last_btn_reg, last_btn_next;
    logic [9:0]           poll_cnt_reg, poll_cnt_next;
    logic [FLASH_W-1:0]   flash_cnt_reg, flash_cnt_next;
    logic [2:0]           mode_reg, mode_next;
    logic [KNOB_BITS-1:0] cap_min_reg, cap_min_next;
    logic [KNOB_BITS-1:0] cap_max_reg, cap_max_next;
    logic [KNOB_BITS-1:0] win_low_reg, win_low_next;
    logic signed [KNOB_BITS:0] win_span_reg, win_span_next;
    logic [KNOB_BITS-1:0] last_knob_reg, last_knob_next;
    logic [KNOB_BITS-1:0] cmd_pos_reg, cmd_pos_next;
    logic [DUTY_W-1:0]    duty_reg, duty_next;

    // output register
    logic                 m_valid_reg, m_valid_next;
    out_item_t            m_item_reg, m_item_next;

    // datapath
    scale_req_t           scale_req;
    scale_rsp_t           scale_rsp;
    logic                 flash_active, poll_due, deb_ok, is_long;
    logic [31:0]          held;
    logic signed [KNOB_BITS:0] cap_span;
    logic                 span_neg;
    logic [KNOB_BITS:0]   span_abs;
    logic signed [KNOB_BITS+1:0] pos_delta, pos_sum;
    logic [KNOB_BITS-1:0] pos_clamped, pos_dir;
    logic signed [DUTY_W:0] duty_diff;
    logic                 diff_neg;
    logic [DUTY_W-1:0]    diff_abs;
    logic signed [DUTY_W+1:0] duty_delta, duty_sum;
    logic [DUTY_W-1:0]    duty_clamped;

    scc_scale u_scale (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (scale_req),
        .rsp     (scale_rsp)
    );

    always_comb begin
        flash_active = (flash_cnt_reg != '0);
        poll_due     = (poll_cnt_reg == '0);
        deb_ok       = (time_reg >= deb_end_reg);
        held         = time_reg - press_start_reg;
        is_long      = (held > {16'd0, long_press_reg});
        cap_span     = $signed({1'b0, cap_max_reg}) - $signed({1'b0, cap_min_reg});

        // window position from the scaled relative value
        span_neg  = win_span_reg[KNOB_BITS];
        span_abs  = span_neg ? $unsigned(-win_span_reg) : $unsigned(win_span_reg);
        pos_delta = $signed({2'b00, scale_rsp.quot[KNOB_BITS-1:0]});
        if (span_neg) begin
            pos_delta = -pos_delta;
        end
        pos_sum = $signed({2'b00, win_low_reg}) + pos_delta;
        if (pos_sum[KNOB_BITS+1]) begin
            pos_clamped = '0;
        end else if (pos_sum[KNOB_BITS]) begin
            pos_clamped = KNOB_MAX;
        end else begin
            pos_clamped = pos_sum[KNOB_BITS-1:0];
        end
        pos_dir = reverse_reg ? (KNOB_MAX - cmd_pos_reg) : cmd_pos_reg;

        // duty between the two limits
        duty_diff  = $signed({1'b0, duty_full_reg}) - $signed({1'b0, duty_zero_reg});
        diff_neg   = duty_diff[DUTY_W];
        diff_abs   = diff_neg ? DUTY_W'(-duty_diff) : duty_diff[DUTY_W-1:0];
        duty_delta = $signed({2'b00, scale_rsp.quot});
        if (diff_neg) begin
            duty_delta = -duty_delta;
        end
        duty_sum = $signed({2'b00, duty_zero_reg}) + duty_delta;
        if (duty_sum[DUTY_W+1]) begin
            duty_clamped = '0;
        end else if (duty_sum[DUTY_W]) begin
            duty_clamped = '1;
        end else begin
            duty_clamped = duty_sum[DUTY_W-1:0];
        end

        scale_req.start = (state_reg == S_POS1) || (state_reg == S_POS2);
        scale_req.frac  = (state_reg == S_POS1) ? rel_reg : pos_dir;
        scale_req.mag   = (state_reg == S_POS1) ? MAG_BITS'(span_abs) : diff_abs;
    end

    always_comb begin
        deb_ticks_next   = deb_ticks_reg;
        long_press_next  = long_press_reg;
        poll_period_next = poll_period_reg;
        thresh_next      = thresh_reg;
        duty_zero_next   = duty_zero_reg;
        duty_full_next   = duty_full_reg;
        reverse_next     = reverse_reg;
        state_next       = state_reg;
        ret_next         = ret_reg;
        btn_next         = btn_reg;
        knob_next        = knob_reg;
        paused_next      = paused_reg;
        poll_act_next    = poll_act_reg;
        short_next       = short_reg;
        long_next        = long_reg;
        rel_next         = rel_reg;
        time_next        = time_reg;
        deb_end_next     = deb_end_reg;
        press_start_next = press_start_reg;
        last_btn_next    = last_btn_reg;
        poll_cnt_next    = poll_cnt_reg;
        flash_cnt_next   = flash_cnt_reg;
        mode_next        = mode_reg;
        cap_min_next     = cap_min_reg;
        cap_max_next     = cap_max_reg;
        win_low_next     = win_low_reg;
        win_span_next    = win_span_reg;
        last_knob_next   = last_knob_reg;
        cmd_pos_next     = cmd_pos_reg;
        duty_next        = duty_reg;
        m_item_next      = m_item_reg;
        m_valid_next     = m_valid_reg && !m_ready;

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_DEBOUNCE:    deb_ticks_next   = cfg_data[7:0];
                REG_LONG_PRESS:  long_press_next  = cfg_data;
                REG_POLL_PERIOD: poll_period_next = cfg_data[9:0];
                REG_KNOB_THRESH: thresh_next      = cfg_data[KNOB_BITS-1:0];
                REG_DUTY_ZERO:   duty_zero_next   = cfg_data;
                REG_DUTY_FULL:   duty_full_next   = cfg_data;
                REG_REVERSE:     reverse_next     = cfg_data[0];
                default: ;
            endcase
        end

        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    btn_next   = s_payload.btn_level;
                    knob_next  = s_payload.knob_sample;
                    state_next = S_EVT;
                end
            end
            S_EVT: begin
                paused_next = flash_active;
                if (flash_active) begin
                    flash_cnt_next = flash_cnt_reg - 1'b1;
                end
                if (poll_due) begin
                    poll_cnt_next = (poll_period_reg == '0) ? '0 : poll_period_reg - 1'b1;
                end else begin
                    poll_cnt_next = poll_cnt_reg - 1'b1;
                end
                poll_act_next = !flash_active && poll_due;
                short_next    = 1'b0;
                long_next     = 1'b0;
                if (!flash_active && (btn_reg != last_btn_reg)) begin
                    last_btn_next = btn_reg;
                    if (deb_ok) begin
                        deb_end_next = time_reg + 32'(deb_ticks_reg);
                        if (btn_reg) begin
                            press_start_next = time_reg;
                        end else begin
                            // release: classify by held time
                            press_start_next = '0;
                            long_next        = is_long;
                            short_next       = !is_long;
                        end
                    end
                end
                time_next  = time_reg + 1'b1;
                state_next = S_PRESS;
            end
            S_PRESS: begin
                state_next = S_POLL;
                ret_next   = S_POLL;
                if (long_reg) begin
                    if (mode_reg != MODE_OPENING && mode_reg <= MODE_PAUSED) begin
                        mode_next     = MODE_OPENING;
                        win_low_next  = '0;
                        win_span_next = $signed({1'b0, KNOB_MAX});
                        rel_next      = '0;
                        state_next    = S_POS1;
                    end
                end else if (short_reg) begin
                    unique case (mode_reg)
                        MODE_OPENING: begin
                            if (knob_reg < thresh_reg) begin
                                mode_next  = MODE_SET_MIN;
                                rel_next   = '0;
                                state_next = S_POS1;
                            end else begin
                                flash_cnt_next = FLASH_LAST;
                            end
                        end
                        MODE_DRIVE_MIN: begin
                            if (knob_reg < thresh_reg) begin
                                mode_next     = MODE_OPERATIONAL;
                                win_low_next  = cap_min_reg;
                                win_span_next = cap_span;
                            end else begin
                                flash_cnt_next = FLASH_LAST;
                            end
                        end
                        MODE_SET_MIN: begin
                            cap_min_next = cmd_pos_reg;
                            mode_next    = MODE_SET_MAX;
                        end
                        MODE_SET_MAX: begin
                            cap_max_next = cmd_pos_reg;
                            mode_next    = MODE_DRIVE_MIN;
                            rel_next     = cap_min_reg;
                            state_next   = S_POS1;
                        end
                        MODE_OPERATIONAL: begin
                            mode_next  = MODE_PAUSED;
                            rel_next   = '0;
                            state_next = S_POS1;
                        end
                        MODE_PAUSED: begin
                            // the paused window already equals the operational one
                            mode_next     = MODE_OPERATIONAL;
                            win_low_next  = cap_min_reg;
                            win_span_next = cap_span;
                            if (knob_reg != last_knob_reg) begin
                                last_knob_next = knob_reg;
                                rel_next       = knob_reg;
                                state_next     = S_POS1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POLL: begin
                state_next = S_FIN;
                if (poll_act_reg && knob_reg != last_knob_reg &&
                    (mode_reg == MODE_SET_MIN || mode_reg == MODE_SET_MAX ||
                     mode_reg == MODE_OPERATIONAL)) begin
                    last_knob_next = knob_reg;
                    rel_next       = knob_reg;
                    ret_next       = S_FIN;
                    state_next     = S_POS1;
                end
            end
            S_POS1: state_next = S_W1;
            S_W1: begin
                if (scale_rsp.done) begin
                    cmd_pos_next = pos_clamped;
                    state_next   = S_POS2;
                end
            end
            S_POS2: state_next = S_W2;
            S_W2: begin
                if (scale_rsp.done) begin
                    duty_next  = duty_clamped & DUTY_MASK;
                    state_next = ret_reg;
                end
            end
            S_FIN: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_item_next.servo_duty  = duty_reg;
                    m_item_next.mode_code   = mode_reg;
                    m_item_next.error_flash = paused_reg || flash_active;
                    m_item_next.led_color   = (paused_reg || flash_active) ?
                                              LED_RED : mode_led(mode_reg);
                    state_next              = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deb_ticks_reg   <= RST_DEBOUNCE;
            long_press_reg  <= RST_LONG_PRESS;
            poll_period_reg <= RST_POLL_PERIOD;
            thresh_reg      <= RST_KNOB_THRESH;
            duty_zero_reg   <= RST_DUTY_ZERO;
            duty_full_reg   <= RST_DUTY_FULL;
            reverse_reg     <= 1'b0;
            state_reg       <= S_IDLE;
            ret_reg         <= S_POLL;
            paused_reg      <= 1'b0;
            poll_act_reg    <= 1'b0;
            short_reg       <= 1'b0;
            long_reg        <= 1'b0;
            time_reg        <= '0;
            deb_end_reg     <= '0;
            press_start_reg <= '0;
            last_btn_reg    <= 1'b0;
            poll_cnt_reg    <= '0;
            flash_cnt_reg   <= '0;
            mode_reg        <= MODE_OPENING;
            cap_min_reg     <= '0;
            cap_max_reg     <= '0;
            win_low_reg     <= '0;
            win_span_reg    <= $signed({1'b0, KNOB_MAX});
            last_knob_reg   <= '0;
            cmd_pos_reg     <= '0;
            duty_reg        <= DUTY_RST;
            m_valid_reg     <= 1'b0;
        end else begin
            deb_ticks_reg   <= deb_ticks_next;
            long_press_reg  <= long_press_next;
            poll_period_reg <= poll_period_next;
            thresh_reg      <= thresh_next;
            duty_zero_reg   <= duty_zero_next;
            duty_full_reg   <= duty_full_next;
            reverse_reg     <= reverse_next;
            state_reg       <= state_next;
            ret_reg         <= ret_next;
            paused_reg      <= paused_next;
            poll_act_reg    <= poll_act_next;
            short_reg       <= short_next;
            long_reg        <= long_next;
            time_reg        <= time_next;
            deb_end_reg     <= deb_end_next;
            press_start_reg <= press_start_next;
            last_btn_reg    <= last_btn_next;
            poll_cnt_reg    <= poll_cnt_next;
            flash_cnt_reg   <= flash_cnt_next;
            mode_reg        <= mode_next;
            cap_min_reg     <= cap_min_next;
            cap_max_reg     <= cap_max_next;
            win_low_reg     <= win_low_next;
            win_span_reg    <= win_span_next;
            last_knob_reg   <= last_knob_next;
            cmd_pos_reg     <= cmd_pos_next;
            duty_reg        <= duty_next;
            m_valid_reg     <= m_valid_next;
        end
        btn_reg    <= btn_next;
        knob_reg   <= knob_next;
        rel_reg    <= rel_next;
        m_item_reg <= m_item_next;
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_item_reg;
    assign cfg_ready = 1'b1;

endmodule

### hdl/scc_scale.sv
// ---------------------------------------------------------------------------
// scc_scale
// Bit-serial scaler: quot = round(frac * mag / KNOB_MAX), ties away from zero.
// MSB-first shift-add multiply, one rounding add, then restoring division
// one quotient bit per cycle. done is registered and rises once the last quotient bit is in.
// ---------------------------------------------------------------------------
module scc_scale (
    input  logic                aclk,
    input  logic                aresetn,
    input  scc_pkg::scale_req_t req,
    output scc_pkg::scale_rsp_t rsp
);
    import scc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_RND  = 2'd2;
    localparam logic [1:0] ST_DIV  = 2'd3;

    logic [1:0]           state_reg, state_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [KNOB_BITS-1:0] frac_reg, frac_next;
    logic [MAG_BITS-1:0]  mag_reg, mag_next;
    logic [MAG_BITS-1:0]  quot_reg, quot_next;
    logic [PROD_BITS-1:0] acc_reg, acc_next;
    logic [PROD_BITS-1:0] div_reg, div_next;
    logic                 done_reg, done_next;
    logic [PROD_BITS-1:0] addend;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        frac_next  = frac_reg;
        mag_next   = mag_reg;
        quot_next  = quot_reg;
        acc_next   = acc_reg;
        div_next   = div_reg;
        done_next  = 1'b0;
        addend     = frac_reg[KNOB_BITS-1] ? PROD_BITS'(mag_reg) : '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (req.start) begin
                    frac_next  = req.frac;
                    mag_next   = req.mag;
                    acc_next   = '0;
                    cnt_next   = CNT_BITS'(KNOB_BITS - 1);
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                acc_next  = (acc_reg << 1) + addend;
                frac_next = frac_reg << 1;
                if (cnt_reg == '0) begin
                    state_next = ST_RND;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            ST_RND: begin
                acc_next   = acc_reg + PROD_BITS'(KNOB_HALF);
                div_next   = PROD_BITS'(KNOB_MAX) << (MAG_BITS - 1);
                quot_next  = '0;
                cnt_next   = CNT_BITS'(MAG_BITS - 1);
                state_next = ST_DIV;
            end
            ST_DIV: begin
                // quotient never exceeds mag, so MAG_BITS steps suffice
                if (acc_reg >= div_reg) begin
                    acc_next  = acc_reg - div_reg;
                    quot_next = {quot_reg[MAG_BITS-2:0], 1'b1};
                end else begin
                    quot_next = {quot_reg[MAG_BITS-2:0], 1'b0};
                end
                div_next = div_reg >> 1;
                if (cnt_reg == '0) begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg  <= cnt_next;
        frac_reg <= frac_next;
        mag_reg  <= mag_next;
        quot_reg <= quot_next;
        acc_reg  <= acc_next;
        div_reg  <= div_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quot_reg;

endmodule

### dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for servo_calibration_controller_core. Ticks are fed
// through a stalling valid/ready driver and predicted in step with
// acceptance. The result monitor compares every field against the oldest
// prediction. Runs a directed calibration walk, then randomized calibration
// rounds and button chatter under several register settings.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import scc_pkg::*;

    localparam int DUTY_KEEP = 16;
    localparam int FLASH_LEN = 400;
    localparam logic [15:0] DUTY_MASK = 16'hFFFF << (16 - DUTY_KEEP);

    logic      aclk      = 1'b0;
    logic      aresetn   = 1'b0;
    logic      s_valid   = 1'b0;
    logic      s_ready;
    in_item_t  s_payload = '0;
    logic      m_valid;
    logic      m_ready   = 1'b0;
    out_item_t m_payload;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [2:0] cfg_index = REG_DEBOUNCE;
    logic [15:0] cfg_data = '0;

    servo_calibration_controller_core #(
        .DUTY_BITS   (DUTY_KEEP),
        .FLASH_TICKS (FLASH_LEN)
    ) u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    in_item_t  tick_q[$];
    out_item_t status_due_q[$];
    int        fails = 0;
    int        results_seen = 0;
    int        phase_ticks = 0;
    logic [11:0] knob_cur = '0;

    // register copies
    logic [7:0]  cfg_debounce;
    logic [15:0] cfg_long_press;
    logic [9:0]  cfg_poll;
    logic [11:0] cfg_thresh;
    logic [15:0] cfg_duty_zero, cfg_duty_full;
    logic        cfg_reverse;

    // controller state
    logic [2:0]  ctl_mode;
    logic [31:0] tick_now, db_end, press_t0;
    logic        btn_prev;
    logic [9:0]  poll_cnt;
    logic [8:0]  flash_cnt;
    logic [11:0] cap_min, cap_max, win_low, knob_prev, cmd_pos;
    int          win_span;
    logic [15:0] duty_q;

    // round(frac * delta / full scale), ties away from zero
    function automatic int scale_span(int delta, int unsigned frac);
        longint unsigned mag;
        longint unsigned q;
        mag = (delta < 0) ? longint'(-delta) : longint'(delta);
        q = (frac * mag + KNOB_HALF) / KNOB_MAX;
        return (delta < 0) ? -int'(q) : int'(q);
    endfunction

    function automatic void place_servo(logic [11:0] rel);
        int a;
        int d;
        logic [11:0] p;
        a = int'(win_low) + scale_span(win_span, rel);
        if (a < 0) a = 0;
        else if (a > int'(KNOB_MAX)) a = int'(KNOB_MAX);
        cmd_pos = a[11:0];
        p = cfg_reverse ? KNOB_MAX - cmd_pos : cmd_pos;
        d = int'(cfg_duty_zero) + scale_span(int'(cfg_duty_full) - int'(cfg_duty_zero), p);
        if (d < 0) d = 0;
        else if (d > 65535) d = 65535;
        duty_q = d[15:0] & DUTY_MASK;
    endfunction

    function automatic void follow_knob(logic [11:0] knob);
        if (knob != knob_prev) begin
            place_servo(knob);
            knob_prev = knob;
        end
    endfunction

    function automatic void enter_mode(logic [2:0] m);
        ctl_mode = m;
        case (m)
            MODE_OPENING: begin
                win_low  = '0;
                win_span = int'(KNOB_MAX);
                place_servo('0);
            end
            MODE_SET_MIN:   place_servo('0);
            MODE_DRIVE_MIN: place_servo(cap_min);
            MODE_OPERATIONAL: begin
                win_low  = cap_min;
                win_span = int'(cap_max) - int'(cap_min);   // may go negative
            end
            MODE_PAUSED:    place_servo('0);
            default: ;
        endcase
    endfunction

    function automatic void handle_release(logic is_long, logic [11:0] knob);
        if (is_long) begin
            if (ctl_mode >= MODE_SET_MIN && ctl_mode <= MODE_PAUSED)
                enter_mode(MODE_OPENING);
        end else begin
            case (ctl_mode)
                MODE_OPENING, MODE_DRIVE_MIN: begin
                    if (knob < cfg_thresh)
                        enter_mode(ctl_mode == MODE_OPENING ? MODE_SET_MIN : MODE_OPERATIONAL);
                    else
                        flash_cnt = 9'(FLASH_LEN);
                end
                MODE_SET_MIN: begin
                    cap_min = cmd_pos;
                    enter_mode(MODE_SET_MAX);
                end
                MODE_SET_MAX: begin
                    cap_max = cmd_pos;
                    enter_mode(MODE_DRIVE_MIN);
                end
                MODE_OPERATIONAL: enter_mode(MODE_PAUSED);
                MODE_PAUSED: begin
                    follow_knob(knob);
                    enter_mode(MODE_OPERATIONAL);
                end
                default: ;
            endcase
        end
    endfunction

    function automatic logic [2:0] color_of(logic [2:0] m);
        case (m)
            MODE_OPENING:     return LED_BLUE;
            MODE_SET_MIN:     return LED_RED;
            MODE_SET_MAX:     return LED_YELLOW;
            MODE_DRIVE_MIN:   return LED_GREEN;
            MODE_OPERATIONAL: return LED_MAGENTA;
            MODE_PAUSED:      return LED_WHITE;
            default:          return LED_OFF;
        endcase
    endfunction

    function automatic void reset_controller();
        cfg_debounce   = RST_DEBOUNCE;
        cfg_long_press = RST_LONG_PRESS;
        cfg_poll       = RST_POLL_PERIOD;
        cfg_thresh     = RST_KNOB_THRESH;
        cfg_duty_zero  = RST_DUTY_ZERO;
        cfg_duty_full  = RST_DUTY_FULL;
        cfg_reverse    = 1'b0;
        tick_now  = '0;
        db_end    = '0;
        press_t0  = '0;
        btn_prev  = 1'b0;
        poll_cnt  = '0;
        flash_cnt = '0;
        cap_min   = '0;
        cap_max   = '0;
        knob_prev = '0;
        enter_mode(MODE_OPENING);
    endfunction

    function automatic void apply_reg(logic [2:0] idx, logic [15:0] val);
        case (idx)
            REG_DEBOUNCE:    cfg_debounce   = val[7:0];
            REG_LONG_PRESS:  cfg_long_press = val;
            REG_POLL_PERIOD: cfg_poll       = val[9:0];
            REG_KNOB_THRESH: cfg_thresh     = val[11:0];
            REG_DUTY_ZERO:   cfg_duty_zero  = val;
            REG_DUTY_FULL:   cfg_duty_full  = val;
            REG_REVERSE:     cfg_reverse    = val[0];
            default: ;
        endcase
    endfunction

    function automatic out_item_t calc_tick_status(in_item_t t);
        out_item_t   r;
        logic [31:0] now;
        logic        hush;
        logic        poll_hit;
        now  = tick_now;
        hush = 1'b0;
        // a running flash mutes the button and the poll
        if (flash_cnt > 1) begin
            flash_cnt = flash_cnt - 1'b1;
            hush = 1'b1;
        end else if (flash_cnt == 1) begin
            flash_cnt = '0;
            hush = 1'b1;
        end
        poll_hit = (poll_cnt == 0);
        if (poll_hit)
            poll_cnt = (cfg_poll == 0) ? 10'd0 : cfg_poll - 10'd1;
        else
            poll_cnt = poll_cnt - 10'd1;
        if (!hush) begin
            if (t.btn_level != btn_prev) begin
                if (now >= db_end) begin
                    db_end = now + 32'(cfg_debounce);
                    if (t.btn_level) begin
                        press_t0 = now;
                    end else begin
                        handle_release((now - press_t0) > 32'(cfg_long_press), t.knob_sample);
                        press_t0 = '0;
                    end
                end
                btn_prev = t.btn_level;
            end
            if (poll_hit && (ctl_mode == MODE_SET_MIN || ctl_mode == MODE_SET_MAX ||
                             ctl_mode == MODE_OPERATIONAL))
                follow_knob(t.knob_sample);
            // the rejecting tick counts as the first flash tick
            if (flash_cnt != 0) flash_cnt = flash_cnt - 1'b1;
        end
        r.servo_duty  = duty_q;
        r.error_flash = hush || (flash_cnt != 0);
        r.led_color   = r.error_flash ? LED_RED : color_of(ctl_mode);
        r.mode_code   = ctl_mode;
        tick_now = now + 32'd1;
        return r;
    endfunction

    function automatic void check_status(out_item_t got);
        out_item_t want;
        results_seen++;
        if (status_due_q.size() == 0) begin
            if (fails < 10)
                $display("result %0d unexpected: duty %0d led %0d mode %0d flash %0d",
                         results_seen, got.servo_duty, got.led_color, got.mode_code,
                         got.error_flash);
            fails++;
        end else begin
            want = status_due_q.pop_front();
            if (got.servo_duty !== want.servo_duty || got.led_color !== want.led_color ||
                got.mode_code !== want.mode_code || got.error_flash !== want.error_flash) begin
                if (fails < 10)
                    $display("result %0d mismatch: exp duty %0d led %0d mode %0d flash %0d, %s",
                             results_seen, want.servo_duty, want.led_color, want.mode_code,
                             want.error_flash,
                             $sformatf("got duty %0d led %0d mode %0d flash %0d",
                                       got.servo_duty, got.led_color, got.mode_code,
                                       got.error_flash));
                fails++;
            end
        end
    endfunction

    // random stalls, with a long quiet stretch every so often
    function automatic logic stall_now();
        if ((($time / 12) % 20000) < 3000) return 1'b0;
        return $urandom_range(0, 99) < 12;
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) status_due_q.push_back(calc_tick_status(s_payload));
            if (!s_valid || s_ready) begin
                if (tick_q.size() != 0 && !stall_now()) begin
                    s_valid   <= 1'b1;
                    s_payload <= tick_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) check_status(m_payload);
            m_ready <= !stall_now();
        end
    end

    // ---- stimulus helpers
    function automatic logic [11:0] wander_knob();
        if ($urandom_range(0, 1)) begin
            case ($urandom_range(0, 9))
                0:       knob_cur = '0;
                1:       knob_cur = KNOB_MAX;
                default: knob_cur = 12'($urandom_range(0, 4095));
            endcase
        end
        return knob_cur;
    endfunction

    function automatic void add_tick(logic btn, logic [11:0] knob);
        in_item_t it;
        it.btn_level   = btn;
        it.knob_sample = knob;
        tick_q.push_back(it);
        phase_ticks++;
    endfunction

    function automatic void idle_ticks(int n);
        repeat (n) add_tick(1'b0, wander_knob());
    endfunction

    function automatic void press(int hold, logic [11:0] rel_knob);
        repeat (hold) add_tick(1'b1, wander_knob());
        add_tick(1'b0, rel_knob);
        knob_cur = rel_knob;
        idle_ticks(int'(cfg_debounce) + $urandom_range(0, 4));
    endfunction

    function automatic void short_press(logic [11:0] k);
        int hold;
        int room;
        hold = (cfg_debounce == 0) ? 1 : int'(cfg_debounce);
        room = int'(cfg_long_press) - hold;
        if (room > 0) hold += $urandom_range(0, room > 2 ? 2 : room);
        press(hold, k);
    endfunction

    function automatic void long_press(logic [11:0] k);
        press(int'(cfg_long_press) + 1 + $urandom_range(0, 3), k);
    endfunction

    // knob on the release of an opening or drive-to-minimum step; rarely rejected, always when the threshold is zero
    function automatic logic [11:0] step_knob();
        if (cfg_thresh == 0 || $urandom_range(0, 19) == 0)
            return 12'($urandom_range(cfg_thresh, 4095));
        return 12'($urandom_range(0, cfg_thresh - 1));
    endfunction

    function automatic void calibration_round();
        if (cfg_long_press < 300) long_press(wander_knob());
        short_press(step_knob());
        idle_ticks($urandom_range(0, 5));
        short_press(wander_knob());
        idle_ticks($urandom_range(0, 5));
        short_press(wander_knob());
        idle_ticks($urandom_range(0, 5));
        short_press(step_knob());
        repeat ($urandom_range(1, 3)) begin
            idle_ticks($urandom_range(1, 8));
            short_press(wander_knob());
            idle_ticks($urandom_range(0, 3));
            short_press(wander_knob());
        end
        idle_ticks($urandom_range(0, 6));
    endfunction

    // bouncing button, ends released
    function automatic void chatter();
        repeat ($urandom_range(3, 15)) add_tick(1'($urandom_range(0, 1)), wander_knob());
        idle_ticks(int'(cfg_debounce) + 1);
    endfunction

    task automatic wait_settled();
        while (tick_q.size() != 0 || status_due_q.size() != 0 || s_valid) @(posedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        apply_reg(idx, val);
        cfg_valid <= 1'b0;
    endtask

    task automatic setup(int dbn, int lp, int poll, int thr, int dz, int df, int rev);
        wait_settled();
        write_reg(REG_DEBOUNCE,    16'(dbn));
        write_reg(REG_LONG_PRESS,  16'(lp));
        write_reg(REG_POLL_PERIOD, 16'(poll));
        write_reg(REG_KNOB_THRESH, 16'(thr));
        write_reg(REG_DUTY_ZERO,   16'(dz));
        write_reg(REG_DUTY_FULL,   16'(df));
        write_reg(REG_REVERSE,     16'(rev));
        phase_ticks = 0;
    endtask

    task automatic random_phase(int budget);
        while (phase_ticks < budget) begin
            if ($urandom_range(0, 9) < 8) calibration_round();
            else chatter();
        end
    endtask

    initial begin
        int dbn;
        reset_controller();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // directed walk: no debounce, poll every tick, long press above 3 ticks
        setup(0, 3, 0, RST_KNOB_THRESH, RST_DUTY_ZERO, RST_DUTY_FULL, 0);
        add_tick(1'b0, 12'd0);
        add_tick(1'b0, KNOB_MAX);
        repeat (4) add_tick(1'b1, 12'd100);      // long press in opening is ignored
        add_tick(1'b0, 12'd100);
        add_tick(1'b1, 12'd0);                   // short press, knob low: set minimum
        add_tick(1'b0, 12'd0);
        add_tick(1'b0, KNOB_MAX);
        add_tick(1'b0, 12'd3000);
        add_tick(1'b1, 12'd3000);                // capture minimum above maximum
        add_tick(1'b0, 12'd3000);
        add_tick(1'b0, 12'd500);
        add_tick(1'b1, 12'd500);                 // capture maximum, drive to minimum
        add_tick(1'b0, 12'd500);
        add_tick(1'b1, KNOB_MAX);                // knob too high: rejected, flash
        add_tick(1'b0, KNOB_MAX);
        add_tick(1'b1, 12'd0);                   // button ignored during flash
        add_tick(1'b1, KNOB_MAX);
        add_tick(1'b0, 12'd2222);
        idle_ticks(FLASH_LEN - 4);
        add_tick(1'b1, 12'd0);                   // accepted: operational, negative span
        add_tick(1'b0, 12'd0);
        add_tick(1'b0, KNOB_MAX);
        add_tick(1'b0, 12'd2048);
        add_tick(1'b0, 12'd0);
        add_tick(1'b1, 12'd1);                   // pause
        add_tick(1'b0, 12'd1);
        add_tick(1'b1, 12'd77);                  // resume from the knob
        add_tick(1'b0, KNOB_MAX);
        repeat (4) add_tick(1'b1, 12'd9);        // long press back to opening
        add_tick(1'b0, 12'd9);
        add_tick(1'b0, 12'd0);

        setup(2, 8, 1, 4095, 65535, 0, 1);
        random_phase(120);
        setup(0, 1, 3, 0, 0, 65535, 0);          // every opening step is rejected
        random_phase(300);
        setup(255, 65535, 1023, RST_KNOB_THRESH, RST_DUTY_ZERO, RST_DUTY_FULL, 0);
        short_press(step_knob());
        idle_ticks(10);
        setup(3, 0, 2, 1000, 40000, 40001, 1);   // every press is long
        random_phase(100);
        repeat (4) begin
            dbn = $urandom_range(0, 6);
            setup(dbn, dbn + $urandom_range(4, 25), $urandom_range(0, 12),
                  $urandom_range(200, 4095), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 1));
            random_phase(100);
        end

        wait_settled();
        repeat (200) @(posedge aclk);
        if (fails == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #40ms;
        $display("== FAIL ==");
        $finish;
    end

endmodule
